### rtl/ile_pkg.sv
package ile_pkg;

	localparam int CMD_W   = 3;
	localparam int POS_W   = 4;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int FPOS_W  = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_SET    = 3'd3,
		CMD_GET    = 3'd4,
		CMD_FIND   = 3'd5,
		CMD_CLEAR  = 3'd6
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_RANGE    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_PUT,
		S_READ,
		S_SHIFT_DOWN,
		S_SCAN,
		S_FINISH
	} state_t;

endpackage

### rtl/ile_if.sv
interface ile_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [ile_pkg::CMD_W-1:0]     command;
	logic [ile_pkg::POS_W-1:0]     position;
	logic [ile_pkg::VALUE_W-1:0]   item_value;

	modport source (output valid, command, position, item_value, input ready);
	modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface ile_res_if;
	logic                          valid;
	logic                          ready;
	logic [ile_pkg::STAT_W-1:0]    status;
	logic [ile_pkg::VALUE_W-1:0]   value_out;
	logic [ile_pkg::FPOS_W-1:0]    found_position;
	logic [ile_pkg::COUNT_W-1:0]   count;
	logic                          empty_res;

	modport source (output valid, status, value_out, found_position, count, empty_res,
		input ready);
	modport sink   (input valid, status, value_out, found_position, count, empty_res,
		output ready);
endinterface

### rtl/indexed_list_engine.sv
// channel  dir  word fields
// -------  ---  ----------------------------------------------------------
// cmd      in   command, position, item_value
// res      out  status, value_out, found_position, count, empty_res
//
// One command at a time; all list entries live in one memory with a single
// write and a single registered read port, so shifts and searches walk it one
// entry per cycle. Append, set, clear, errors, insert at the end and the unused
// code 7 finish at once; get reads one entry; insert inside shifts up from the
// last entry to pos, then writes; remove shifts later entries down; find scans to a hit.
// arst_n clears the state, the count and the result valid; entries are never cleared.
// A stalled result holds in its register; one more command may be accepted
// meanwhile and waits in its last cycle until the register frees.
module indexed_list_engine #(
	parameter int CAPACITY   = 16,
	parameter int ITEM_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ile_cmd_if.sink    cmd,
	ile_res_if.source  res
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

	ile_pkg::state_t state_q, state_d;

	logic [CW-1:0]          count_q, count_d;
	logic [IW-1:0]          idx_q, idx_d;
	logic [IW-1:0]          pos_q;
	logic [ITEM_WIDTH-1:0]  item_q;
	ile_pkg::cmd_t          cmd_q;
	ile_pkg::stat_t         st_q, st_d;
	logic [ITEM_WIDTH-1:0]  val_q, val_d;
	logic [IW-1:0]          fpos_q, fpos_d;

	logic                   res_valid_q;
	ile_pkg::stat_t         res_status_q;
	logic [ITEM_WIDTH-1:0]  res_val_q;
	logic [IW-1:0]          res_fpos_q;
	logic [CW-1:0]          res_count_q;

	logic [ITEM_WIDTH-1:0]  mem [CAPACITY];
	logic [ITEM_WIDTH-1:0]  rd_q;
	logic                   mem_we, mem_re;
	logic [IW-1:0]          mem_wa, mem_ra;
	logic [ITEM_WIDTH-1:0]  mem_wd;

	logic                   accept, res_free, res_load;
	ile_pkg::cmd_t          in_cmd;
	logic [ITEM_WIDTH-1:0]  in_item;
	logic [LW-1:0]          in_pos_w, cnt_w;
	logic                   is_full, pos_lt_cnt, pos_eq_cnt;
	logic                   last_idx, hit, at_pos;

	assign cmd.ready = (state_q == ile_pkg::S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign res_free  = !res_valid_q || res.ready;

	assign in_cmd     = ile_pkg::cmd_t'(cmd.command);
	assign in_item    = ITEM_WIDTH'(cmd.item_value);
	assign in_pos_w   = LW'(cmd.position);
	assign cnt_w      = LW'(count_q);
	assign is_full    = (count_q == CW'(CAPACITY));
	assign pos_lt_cnt = (in_pos_w < cnt_w);
	assign pos_eq_cnt = (in_pos_w == cnt_w);

	assign last_idx = ((CW'(idx_q) + CW'(1)) == count_q);
	assign hit      = (rd_q == item_q);
	assign at_pos   = (idx_q == pos_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ile_pkg::S_IDLE: begin
				if (accept) begin
					state_d = ile_pkg::S_FINISH;
					case (in_cmd)
						ile_pkg::CMD_INSERT: begin
							if (!is_full && pos_lt_cnt)
								state_d = ile_pkg::S_SHIFT_UP;
						end
						ile_pkg::CMD_REMOVE, ile_pkg::CMD_GET: begin
							if (pos_lt_cnt)
								state_d = ile_pkg::S_READ;
						end
						ile_pkg::CMD_FIND: begin
							if (count_q != '0)
								state_d = ile_pkg::S_SCAN;
						end
						default: state_d = ile_pkg::S_FINISH;
					endcase
				end
			end
			ile_pkg::S_SHIFT_UP: begin
				if (at_pos)
					state_d = ile_pkg::S_PUT;
			end
			ile_pkg::S_PUT: state_d = ile_pkg::S_FINISH;
			ile_pkg::S_READ: begin
				if (cmd_q == ile_pkg::CMD_GET || last_idx)
					state_d = ile_pkg::S_FINISH;
				else
					state_d = ile_pkg::S_SHIFT_DOWN;
			end
			ile_pkg::S_SHIFT_DOWN: begin
				if (last_idx)
					state_d = ile_pkg::S_FINISH;
			end
			ile_pkg::S_SCAN: begin
				if (hit || last_idx)
					state_d = ile_pkg::S_FINISH;
			end
			ile_pkg::S_FINISH: begin
				if (res_free)
					state_d = ile_pkg::S_IDLE;
			end
			default: state_d = ile_pkg::S_IDLE;
		endcase
	end

	// memory control and datapath updates
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = idx_q;
		mem_wd   = item_q;
		mem_re   = 1'b0;
		mem_ra   = idx_q;
		idx_d    = idx_q;
		count_d  = count_q;
		st_d     = st_q;
		val_d    = val_q;
		fpos_d   = fpos_q;
		res_load = 1'b0;
		unique case (state_q)
			ile_pkg::S_IDLE: begin
				if (accept) begin
					st_d   = ile_pkg::STAT_OK;
					val_d  = '0;
					fpos_d = '0;
					case (in_cmd)
						ile_pkg::CMD_APPEND: begin
							if (is_full) begin
								st_d = ile_pkg::STAT_FULL;
							end else begin
								mem_we  = 1'b1;
								mem_wa  = IW'(count_q);
								mem_wd  = in_item;
								count_d = count_q + CW'(1);
							end
						end
						ile_pkg::CMD_INSERT: begin
							if (is_full) begin
								st_d = ile_pkg::STAT_FULL;
							end else if (pos_eq_cnt) begin
								mem_we  = 1'b1;
								mem_wa  = IW'(count_q);
								mem_wd  = in_item;
								count_d = count_q + CW'(1);
							end else if (pos_lt_cnt) begin
								// start the upward shift from the last entry
								mem_re = 1'b1;
								mem_ra = IW'(count_q - CW'(1));
								idx_d  = IW'(count_q - CW'(1));
							end else begin
								st_d = ile_pkg::STAT_RANGE;
							end
						end
						ile_pkg::CMD_REMOVE, ile_pkg::CMD_GET: begin
							if (pos_lt_cnt) begin
								mem_re = 1'b1;
								mem_ra = IW'(cmd.position);
								idx_d  = IW'(cmd.position);
							end else begin
								st_d = ile_pkg::STAT_RANGE;
							end
						end
						ile_pkg::CMD_SET: begin
							if (pos_lt_cnt) begin
								mem_we = 1'b1;
								mem_wa = IW'(cmd.position);
								mem_wd = in_item;
							end else begin
								st_d = ile_pkg::STAT_RANGE;
							end
						end
						ile_pkg::CMD_FIND: begin
							st_d = ile_pkg::STAT_NOTFOUND;
							if (count_q != '0) begin
								mem_re = 1'b1;
								mem_ra = '0;
								idx_d  = '0;
							end
						end
						ile_pkg::CMD_CLEAR: count_d = '0;
						default: ;
					endcase
				end
			end
			ile_pkg::S_SHIFT_UP: begin
				// rd_q holds entry idx_q, moving to idx_q + 1
				mem_we = 1'b1;
				mem_wa = idx_q + IW'(1);
				mem_wd = rd_q;
				if (!at_pos) begin
					mem_re = 1'b1;
					mem_ra = idx_q - IW'(1);
					idx_d  = idx_q - IW'(1);
				end
			end
			ile_pkg::S_PUT: begin
				mem_we  = 1'b1;
				mem_wa  = pos_q;
				mem_wd  = item_q;
				count_d = count_q + CW'(1);
			end
			ile_pkg::S_READ: begin
				val_d = rd_q;
				if (cmd_q == ile_pkg::CMD_REMOVE) begin
					if (last_idx) begin
						count_d = count_q - CW'(1);
					end else begin
						mem_re = 1'b1;
						mem_ra = idx_q + IW'(1);
						idx_d  = idx_q + IW'(1);
					end
				end
			end
			ile_pkg::S_SHIFT_DOWN: begin
				mem_we = 1'b1;
				mem_wa = idx_q - IW'(1);
				mem_wd = rd_q;
				if (last_idx) begin
					count_d = count_q - CW'(1);
				end else begin
					mem_re = 1'b1;
					mem_ra = idx_q + IW'(1);
					idx_d  = idx_q + IW'(1);
				end
			end
			ile_pkg::S_SCAN: begin
				if (hit) begin
					st_d   = ile_pkg::STAT_OK;
					fpos_d = idx_q;
				end else if (!last_idx) begin
					mem_re = 1'b1;
					mem_ra = idx_q + IW'(1);
					idx_d  = idx_q + IW'(1);
				end
			end
			ile_pkg::S_FINISH: res_load = res_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ile_pkg::S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		st_q   <= st_d;
		val_q  <= val_d;
		fpos_q <= fpos_d;
		if (accept) begin
			cmd_q  <= in_cmd;
			pos_q  <= IW'(cmd.position);
			item_q <= in_item;
		end
		if (res_load) begin
			res_status_q <= st_q;
			res_val_q    <= val_q;
			res_fpos_q   <= fpos_q;
			res_count_q  <= count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem[mem_ra];
	end

	assign res.valid          = res_valid_q;
	assign res.status         = res_status_q;
	assign res.value_out      = ile_pkg::VALUE_W'(res_val_q);
	assign res.found_position = ile_pkg::FPOS_W'(res_fpos_q);
	assign res.count          = ile_pkg::COUNT_W'(res_count_q);
	assign res.empty_res      = (res_count_q == '0);

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ile_pkg::S_FINISH && st_q == ile_pkg::STAT_FULL)
		|-> count_q == CW'(CAPACITY))
		else $error("full status with room left");

	a_walk_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ile_pkg::S_SHIFT_UP || state_q == ile_pkg::S_READ ||
		 state_q == ile_pkg::S_SHIFT_DOWN || state_q == ile_pkg::S_SCAN)
		|-> CW'(idx_q) < count_q)
		else $error("memory walk beyond the count");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> mem_wa != mem_ra)
		else $error("read and write of the same entry in one cycle");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_cmd == ile_pkg::CMD_CLEAR) |=> count_q == '0)
		else $error("clear left entries");

endmodule
